// ===== hdl/arh_pkg.sv =====
// Types, constants and codes shared by the auto-ranging histogram modules.
package arh_pkg;

   localparam int ARH_NUM_BINS    = 16;
   localparam int ARH_COUNT_WIDTH = 32;

   // Doubling stops once the bin size reaches 2^31.
   localparam logic [4:0] SHIFT_CAP = 5'd31;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic               op;
      logic signed [31:0] sample;
   } req_type;

   typedef struct packed {
      logic [3:0]  bin_index;
      logic [30:0] bin_low;
      logic [30:0] bin_high;
      logic [31:0] bin_count;
      logic [27:0] bin_size;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INC_WR,
      ST_MRG_RD,
      ST_MRG_WR,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_WAIT
   } arh_state_type;

   typedef struct packed {
      logic load_req;
      logic rd_pos;
      logic wr_inc;
      logic rd_merge;
      logic wr_merge;
      logic merge_next;
      logic merge_done;
      logic rd_out;
      logic load_out;
      logic out_next;
   } arh_cmd_type;

   typedef struct packed {
      logic need_merge;
      logic merge_last;
      logic out_last;
   } arh_sts_type;

endpackage

// ===== hdl/arh_datapath.sv =====
// Datapath: bin count memory, valid bits, scale, index counter and result register.
module arh_datapath
   import arh_pkg::*;
#(
   parameter int NUM_BINS    = ARH_NUM_BINS,
   parameter int COUNT_WIDTH = ARH_COUNT_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  arh_cmd_type cmd,
   output arh_sts_type sts,
   output rsp_type     rsp_data
);

   localparam int IW   = $clog2(NUM_BINS);
   localparam int HALF = (NUM_BINS + 1) / 2;
   localparam int CW   = COUNT_WIDTH;

   logic [CW-1:0]       mem_ff [NUM_BINS];
   logic [NUM_BINS-1:0] valid_ff;
   logic [NUM_BINS-1:0] valid_in;
   logic [30:0]         sample_ff;
   logic [4:0]          shift_ff;
   logic [4:0]          shift_in;
   logic [IW-1:0]       idx_ff;
   logic [IW-1:0]       idx_in;
   logic [CW-1:0]       rd_a_ff;
   logic [CW-1:0]       rd_b_ff;
   logic                rv_a_ff;
   logic                rv_b_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic [31:0]   scaled;
   logic [IW-1:0] pos_idx;
   logic [IW-1:0] addr_lo;
   logic [IW-1:0] addr_hi;
   logic          pair_ok;
   logic [IW-1:0] rd_addr_a;
   logic [IW-1:0] rd_addr_b;
   logic          rd_en;
   logic [CW-1:0] a_val;
   logic [CW-1:0] b_val;
   logic [CW-1:0] opnd_b;
   logic [CW:0]   sum;
   logic [CW-1:0] wr_data_in;
   logic [IW-1:0] wr_addr;
   logic          wr_en;
   logic [63:0]   count_wide;
   logic [30:0]   idx_wide;

   // Bin position of the held sample at the current scale
   assign scaled  = {1'b0, sample_ff} >> shift_ff;
   assign pos_idx = (scaled >= 32'(NUM_BINS)) ? IW'(NUM_BINS - 1) : scaled[IW-1:0];

   assign addr_lo = idx_ff << 1;
   assign addr_hi = addr_lo | IW'(1);
   assign pair_ok = ({1'b0, addr_lo} + (IW+1)'(1)) < (IW+1)'(NUM_BINS);

   assign rd_en     = cmd.rd_pos | cmd.rd_merge | cmd.rd_out;
   assign rd_addr_a = cmd.rd_pos ? pos_idx : (cmd.rd_merge ? addr_lo : idx_ff);
   assign rd_addr_b = pair_ok ? addr_hi : addr_lo;

   // An entry without its valid bit reads as zero
   assign a_val  = rv_a_ff ? rd_a_ff : '0;
   assign b_val  = rv_b_ff ? rd_b_ff : '0;
   assign opnd_b = cmd.wr_merge ? b_val : CW'(1);
   assign sum    = {1'b0, a_val} + {1'b0, opnd_b};

   always_comb begin
      wr_data_in = sum[CW] ? '1 : sum[CW-1:0];
   end

   assign wr_en   = cmd.wr_inc | cmd.wr_merge;
   assign wr_addr = cmd.wr_merge ? idx_ff : pos_idx;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data_in;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
         rv_a_ff <= valid_ff[rd_addr_a];
         rv_b_ff <= valid_ff[rd_addr_b] & cmd.rd_merge & pair_ok;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      // Clear the upper half once the pairs have been folded down
      if (cmd.merge_done) begin
         for (int k = HALF; k < NUM_BINS; k++) begin
            valid_in[k] = 1'b0;
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      if (cmd.merge_done) begin
         shift_in = shift_ff + 5'd1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load_req || cmd.merge_done) begin
         idx_in = '0;
      end else if (cmd.merge_next || cmd.out_next) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   assign count_wide = 64'(a_val);
   assign idx_wide   = 31'(idx_ff);

   always_comb begin
      rsp_in           = rsp_ff;
      rsp_in.bin_index = idx_wide[3:0];
      rsp_in.bin_low   = idx_wide << shift_ff;
      rsp_in.bin_high  = ((idx_wide + 31'd1) << shift_ff) - 31'd1;
      rsp_in.bin_count = (count_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                  : count_wide[31:0];
      rsp_in.bin_size  = 28'd1 << shift_ff;
      rsp_in.last      = sts.out_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         shift_ff <= '0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         shift_ff <= shift_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         sample_ff <= req_data.sample[30:0];
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.need_merge = (shift_ff < SHIFT_CAP) && (scaled >= 32'(NUM_BINS));
   assign sts.merge_last = (idx_ff == IW'(HALF - 1));
   assign sts.out_last   = (idx_ff == IW'(NUM_BINS - 1));

   assign rsp_data = rsp_ff;

endmodule

// ===== hdl/arh_controller.sv =====
// Controller: sequences sample updates, range doublings and bin readout.
module arh_controller
   import arh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  arh_sts_type sts,
   output arh_cmd_type cmd
);

   arh_state_type state_ff;
   arh_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.op == OP_READ) begin
                  state_in = ST_OUT_RD;
               end else if (!req_data.sample[31]) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            state_in = sts.need_merge ? ST_MRG_RD : ST_INC_WR;
         end
         ST_INC_WR: begin
            state_in = ST_IDLE;
         end
         ST_MRG_RD: begin
            state_in = ST_MRG_WR;
         end
         ST_MRG_WR: begin
            state_in = sts.merge_last ? ST_CHECK : ST_MRG_RD;
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_ready) begin
               state_in = sts.out_last ? ST_IDLE : ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_CHECK: begin
            cmd.rd_pos = !sts.need_merge;
         end
         ST_INC_WR: begin
            cmd.wr_inc = 1'b1;
         end
         ST_MRG_RD: begin
            cmd.rd_merge = 1'b1;
         end
         ST_MRG_WR: begin
            cmd.wr_merge   = 1'b1;
            cmd.merge_next = !sts.merge_last;
            cmd.merge_done = sts.merge_last;
         end
         ST_OUT_RD: begin
            cmd.rd_out = 1'b1;
         end
         ST_OUT_LD: begin
            cmd.load_out = 1'b1;
         end
         ST_OUT_WAIT: begin
            rsp_valid    = 1'b1;
            cmd.out_next = rsp_ready && !sts.out_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/auto_ranging_histogram.sv =====
// Top level of the auto-ranging histogram: controller plus datapath.
//
// Counts non-negative samples into NUM_BINS bins of width 2^shift; a sample past
// the covered range doubles the bin width, folding bin pairs 2j and 2j+1 into bin j
// and clearing the upper half, once per doubling. An add transfer steps through the
// accept, the range check with count read and count write, set by the registered
// read of the count memory; a negative sample is dropped when taken. Each doubling
// runs a read and a write state per bin pair; at most 27 doublings occur with 16
// bins. A readout yields NUM_BINS results, each through a read, a load and a wait
// state held while the result side stalls, and no new item is taken until the last
// one is gone. Counts saturate; bins are zero out of reset, with no clearing pass.
module auto_ranging_histogram
   import arh_pkg::*;
#(
   parameter int NUM_BINS    = ARH_NUM_BINS,
   parameter int COUNT_WIDTH = ARH_COUNT_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   arh_cmd_type cmd;
   arh_sts_type sts;

   arh_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   arh_datapath #(
      .NUM_BINS    (NUM_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hdl/arh_checker.sv =====
// Port-level checks for the auto-ranging histogram, bound to the top level.
module arh_checker
   import arh_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Take no item while a readout is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready during readout");

   // Return to idle after the final bin transfer
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last |=> req_ready && !rsp_valid)
      else $error("not idle after last bin");

   // An add transfer yields no result
   a_add_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == OP_ADD |=> !rsp_valid)
      else $error("result after add");

   a_size_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_data.bin_size))
      else $error("bin size not a power of two");

endmodule

bind auto_ranging_histogram arh_checker u_arh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/auto_ranging_histogram_test.sv =====
// Self-checking testbench for the auto-ranging histogram: directed table plus random climb.
`timescale 1ns / 1ps

module auto_ranging_histogram_test;
   import arh_pkg::*;

   localparam int NB          = ARH_NUM_BINS;
   localparam int N_DIRECTED  = 17;
   localparam int N_RANDOM    = 310;
   localparam int QUIET_ITEMS = 40;
   localparam int DRAIN_WAIT  = 200;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_SHOWN   = 10;

   // One row of the directed table; pinned rows carry a typed readout
   // (bin size, and a mask of bins holding a single count, all others empty).
   typedef struct packed {
      logic        op;
      logic [31:0] sample;
      logic        pinned;
      logic [27:0] pin_size;
      logic [15:0] pin_ones;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // histogram mirror
   logic [31:0] hist_counts [NB];
   logic [4:0]  hist_shift;
   rsp_type     bin_reports_due [$];

   int mismatches  = 0;
   int cycle_count = 0;
   int stall_left  = 0;
   bit quiet_tail  = 1'b0;

   auto_ranging_histogram u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side back-pressure: random bursts of stalls.
   always @(negedge clock) begin
      if (quiet_tail) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic stim_row_type directed_row(int k);
      stim_row_type r;
      r = '0;
      case (k)
         0:  r = '{OP_READ, 32'd0,          1'b1, 28'd1, 16'h0000};
         1:  r = '{OP_ADD,  32'd0,          1'b0, 28'd0, 16'h0000};
         2:  r = '{OP_ADD,  32'd15,         1'b0, 28'd0, 16'h0000};
         3:  r = '{OP_READ, 32'd0,          1'b1, 28'd1, 16'h8001};
         4:  r = '{OP_ADD,  32'hFFFF_FFFF,  1'b0, 28'd0, 16'h0000};
         5:  r = '{OP_ADD,  32'h8000_0000,  1'b0, 28'd0, 16'h0000};
         6:  r = '{OP_ADD,  32'd16,         1'b0, 28'd0, 16'h0000};
         // one fold: bins 0 and 7 keep the old counts, the sample lands in bin 8
         7:  r = '{OP_READ, 32'd0,          1'b1, 28'd2, 16'h0181};
         8:  r = '{OP_ADD,  32'd31,         1'b0, 28'd0, 16'h0000};
         9:  r = '{OP_ADD,  32'd32,         1'b0, 28'd0, 16'h0000};
         10: r = '{OP_ADD,  32'd100,        1'b0, 28'd0, 16'h0000};
         // several doublings from one sample
         11: r = '{OP_ADD,  32'd1000,       1'b0, 28'd0, 16'h0000};
         12: r = '{OP_READ, 32'd0,          1'b0, 28'd0, 16'h0000};
         13: r = '{OP_READ, 32'hDEAD_BEEF,  1'b0, 28'd0, 16'h0000};
         14: r = '{OP_ADD,  32'd1,          1'b0, 28'd0, 16'h0000};
         15: r = '{OP_ADD,  32'd64,         1'b0, 28'd0, 16'h0000};
         16: r = '{OP_READ, 32'd0,          1'b0, 28'd0, 16'h0000};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic rsp_type bin_report(int idx, logic [27:0] size, logic [31:0] cnt);
      rsp_type     r;
      logic [63:0] lo;
      logic [63:0] hi;
      lo = 64'(idx) * 64'(size);
      hi = 64'(idx + 1) * 64'(size) - 64'd1;
      r.bin_index = 4'(idx);
      r.bin_low   = lo[30:0];
      r.bin_high  = hi[30:0];
      r.bin_count = cnt;
      r.bin_size  = size;
      r.last      = (idx == NB - 1);
      return r;
   endfunction

   // Fold pairs 2j, 2j+1 into bin j, saturating, and empty the upper half.
   task automatic fold_bins();
      logic [32:0] sum;
      for (int j = 0; j < NB / 2; j++) begin
         sum = {1'b0, hist_counts[2 * j]} + {1'b0, hist_counts[2 * j + 1]};
         hist_counts[j] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      for (int j = NB / 2; j < NB; j++) hist_counts[j] = '0;
   endtask

   task automatic count_sample(logic [31:0] s);
      logic [63:0] pos;
      if (s[31]) return;
      while (hist_shift < SHIFT_CAP && 64'(s) >= (64'(NB) << hist_shift)) begin
         hist_shift++;
         fold_bins();
      end
      pos = 64'(s) >> hist_shift;
      if (pos >= 64'(NB)) pos = 64'(NB - 1);
      if (hist_counts[pos] != 32'hFFFF_FFFF) hist_counts[pos]++;
   endtask

   task automatic push_readout(bit pinned, logic [27:0] pin_size, logic [15:0] pin_ones);
      logic [63:0] size_w;
      logic [27:0] size;
      size_w = 64'd1 << hist_shift;
      size   = pinned ? pin_size : size_w[27:0];
      for (int i = 0; i < NB; i++)
         bin_reports_due.push_back(bin_report(i, size,
            pinned ? 32'(pin_ones[i]) : hist_counts[i]));
   endtask

   // Drop valid for a random burst, unless in the quiet tail.
   task automatic sender_gap();
      int n;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 9);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_item(logic op, logic [31:0] sample, bit pinned,
                            logic [27:0] pin_size, logic [15:0] pin_ones);
      req_type item;
      item.op     = op;
      item.sample = sample;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (op == OP_READ) push_readout(pinned, pin_size, pin_ones);
      else count_sample(sample);
   endtask

   task automatic check_report(rsp_type got);
      rsp_type want;
      if (bin_reports_due.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_SHOWN)
            $display("unexpected bin report: index %0d count %0d", got.bin_index,
                     got.bin_count);
         return;
      end
      want = bin_reports_due.pop_front();
      if (got.bin_index !== want.bin_index || got.bin_low !== want.bin_low ||
          got.bin_high !== want.bin_high || got.bin_count !== want.bin_count ||
          got.bin_size !== want.bin_size || got.last !== want.last) begin
         mismatches++;
         if (mismatches <= MAX_SHOWN) begin
            $display("mismatch: expected idx %0d low %0d high %0d count %0d size %0d last %0b",
                     want.bin_index, want.bin_low, want.bin_high, want.bin_count,
                     want.bin_size, want.last);
            $display("          actual   idx %0d low %0d high %0d count %0d size %0d last %0b",
                     got.bin_index, got.bin_low, got.bin_high, got.bin_count,
                     got.bin_size, got.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_report(rsp_data);
   end

   initial begin
      stim_row_type row;
      int           ceil_exp;
      int           pick;
      logic [63:0]  mask;
      logic [63:0]  range_top;
      logic [31:0]  sample;
      logic         op;

      for (int i = 0; i < NB; i++) hist_counts[i] = '0;
      hist_shift = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < N_DIRECTED; k++) begin
         sender_gap();
         row = directed_row(k);
         send_item(row.op, row.sample, row.pinned, row.pin_size, row.pin_ones);
      end

      // Random climb: the sample ceiling grows over the run so that every
      // doubling step is reached gradually, with readouts in between.
      for (int k = 0; k < N_RANDOM; k++) begin
         if (k >= N_RANDOM - QUIET_ITEMS) quiet_tail = 1'b1;
         sender_gap();
         ceil_exp = 4 + (k * 28) / N_RANDOM;
         if (ceil_exp > 31) ceil_exp = 31;
         mask = (64'd1 << ceil_exp) - 64'd1;
         pick = $urandom_range(0, 99);
         op   = OP_ADD;
         if (pick < 8) begin
            sample = {1'b1, 31'($urandom)};
         end else if (pick < 20) begin
            op     = OP_READ;
            sample = $urandom;
         end else if (pick < 30) begin
            // sit on the edge of the covered range
            range_top = (64'(NB) << hist_shift) - 64'($urandom_range(0, 1));
            sample    = range_top[31:0];
         end else if (pick < 40) begin
            sample = $urandom_range(0, 15);
         end else begin
            sample = $urandom & mask[31:0];
         end
         send_item(op, sample, 1'b0, '0, '0);
      end

      send_item(OP_ADD, 32'h7FFF_FFFF, 1'b0, '0, '0);
      send_item(OP_READ, 32'd0, 1'b0, '0, '0);
      @(negedge clock);
      req_valid <= 1'b0;

      while (bin_reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      mismatches += bin_reports_due.size();

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/arh_pkg.sv
hdl/arh_datapath.sv
hdl/arh_controller.sv
hdl/auto_ranging_histogram.sv
hdl/arh_checker.sv
tb/sv/auto_ranging_histogram_test.sv
